// File: rtl/aptb_pkg.sv
package aptb_pkg;

   localparam int unsigned NUM_W  = 26;   // initial_tokens * 1000 fits 26 bits
   localparam int unsigned PROD_W = 50;   // 32-bit gap times 18-bit rate

   localparam logic [9:0]  MS_PER_S = 10'd1000;

   localparam logic [15:0] INITIAL_TOKENS_RST     = 16'd6600;
   localparam logic [15:0] REFILL_TOKENS_RST      = 16'd441;
   localparam logic [15:0] REFILL_INTERVAL_MS_RST = 16'd10;
   localparam logic [31:0] RESET_GAP_MS_RST       = 32'd149;

   typedef enum logic [1:0] {
      CSR_INITIAL_TOKENS     = 2'd0,
      CSR_REFILL_TOKENS      = 2'd1,
      CSR_REFILL_INTERVAL_MS = 2'd2,
      CSR_RESET_GAP_MS       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      VERDICT_SEND      = 2'd0,
      VERDICT_EARLY     = 2'd1,
      VERDICT_NO_TOKENS = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [15:0] packet_samples;
      logic [31:0] play_time_ms;
      logic [17:0] sample_rate;
   } req_type;

   typedef struct packed {
      verdict_type verdict;
      logic [31:0] tokens_left;
   } rsp_type;

   typedef struct packed {
      logic [15:0] initial_tokens;
      logic [15:0] refill_tokens;
      logic [15:0] refill_interval_ms;
      logic [31:0] reset_gap_ms;
   } cfg_type;

   // classified word handed from front to back
   typedef struct packed {
      logic        early;
      logic [31:0] now_ms;
      logic [15:0] packet_samples;
   } cls_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_REFILL,
      BACK_SPEND
   } back_state_type;

endpackage

// File: rtl/aptb_csr.sv
module aptb_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output aptb_pkg::cfg_type cfg
);
   import aptb_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_INITIAL_TOKENS:     cfg_in.initial_tokens     = csr_pwdata[15:0];
            CSR_REFILL_TOKENS:      cfg_in.refill_tokens      = csr_pwdata[15:0];
            CSR_REFILL_INTERVAL_MS: cfg_in.refill_interval_ms = csr_pwdata[15:0];
            CSR_RESET_GAP_MS:       cfg_in.reset_gap_ms       = csr_pwdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_INITIAL_TOKENS:     csr_prdata = {16'b0, cfg_ff.initial_tokens};
         CSR_REFILL_TOKENS:      csr_prdata = {16'b0, cfg_ff.refill_tokens};
         CSR_REFILL_INTERVAL_MS: csr_prdata = {16'b0, cfg_ff.refill_interval_ms};
         CSR_RESET_GAP_MS:       csr_prdata = cfg_ff.reset_gap_ms;
         default:                csr_prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_tokens     <= INITIAL_TOKENS_RST;
         cfg_ff.refill_tokens      <= REFILL_TOKENS_RST;
         cfg_ff.refill_interval_ms <= REFILL_INTERVAL_MS_RST;
         cfg_ff.reset_gap_ms       <= RESET_GAP_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/aptb_fifo.sv
module aptb_fifo #(
   parameter type word_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  word_type push_word,
   output logic     full,
   input  logic     pop,
   output word_type pop_word,
   output logic     empty
);

   word_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_word = mem_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/aptb_front.sv
module aptb_front (
   input  logic              clock,
   input  logic              reset,
   input  aptb_pkg::cfg_type cfg,
   input  logic              req_push,
   input  aptb_pkg::req_type req_data,
   output logic              req_full,
   output logic              cls_push,
   output aptb_pkg::cls_type cls_word,
   input  logic              cls_full
);
   import aptb_pkg::*;

   // stage 1: accepted word
   req_type             item_ff, item_in;
   logic                s1_valid_ff, s1_valid_in;
   // stage 2: products and early-window compare
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic                cand_ff, cand_in;
   logic [31:0]         now_ff, now_in;
   logic [15:0]         cost_ff, cost_in;
   logic                s2_valid_ff, s2_valid_in;

   logic                accept, advance;
   logic [31:0]         gap;

   assign req_full = s1_valid_ff;
   assign accept   = req_push & ~s1_valid_ff;
   assign cls_push = s2_valid_ff;
   assign advance  = s1_valid_ff & (~s2_valid_ff | ~cls_full);

   // gap > floor(num/rate) is the same as gap*rate > num; rate zero never holds
   assign gap = item_ff.play_time_ms - item_ff.now_ms;

   always_comb begin
      item_in = accept ? req_data : item_ff;

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      if (advance) begin
         s2_valid_in = 1'b1;
      end else if (s2_valid_ff & ~cls_full) begin
         s2_valid_in = 1'b0;
      end

      prod_in = prod_ff;
      num_in  = num_ff;
      cand_in = cand_ff;
      now_in  = now_ff;
      cost_in = cost_ff;
      if (advance) begin
         prod_in = {{(PROD_W-32){1'b0}}, gap} * {{(PROD_W-18){1'b0}}, item_ff.sample_rate};
         num_in  = {{(NUM_W-16){1'b0}}, cfg.initial_tokens} *
                   {{(NUM_W-10){1'b0}}, MS_PER_S};
         cand_in = (item_ff.play_time_ms != 32'd0) &&
                   (item_ff.play_time_ms > item_ff.now_ms);
         now_in  = item_ff.now_ms;
         cost_in = item_ff.packet_samples;
      end
   end

   always_comb begin
      cls_word.early          = cand_ff && (prod_ff > {{(PROD_W-NUM_W){1'b0}}, num_ff});
      cls_word.now_ms         = now_ff;
      cls_word.packet_samples = cost_ff;
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      cand_ff <= cand_in;
      now_ff  <= now_in;
      cost_ff <= cost_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

endmodule

// File: rtl/aptb_back.sv
module aptb_back (
   input  logic              clock,
   input  logic              reset,
   input  aptb_pkg::cfg_type cfg,
   input  logic              cls_empty,
   input  aptb_pkg::cls_type cls_word,
   output logic              cls_pop,
   output logic              out_push,
   output aptb_pkg::rsp_type out_word,
   input  logic              out_full
);
   import aptb_pkg::*;

   back_state_type state_ff, state_in;
   cls_type        item_ff, item_in;
   logic [31:0]    bucket_ff, bucket_in;
   logic [31:0]    last_ff, last_in;

   logic [31:0]    due_ms, gap_ms;
   logic [32:0]    topped;
   logic [31:0]    cost;

   assign due_ms = last_ff + {16'b0, cfg.refill_interval_ms};
   assign gap_ms = last_ff + cfg.reset_gap_ms;
   assign topped = {1'b0, bucket_ff} + {17'b0, cfg.refill_tokens};
   assign cost   = {16'b0, item_ff.packet_samples};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!cls_empty) begin
               state_in = BACK_REFILL;
            end
         end
         BACK_REFILL: state_in = BACK_SPEND;
         BACK_SPEND: begin
            if (!out_full) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      cls_pop              = 1'b0;
      out_push             = 1'b0;
      item_in              = item_ff;
      bucket_in            = bucket_ff;
      last_in              = last_ff;
      out_word.verdict     = VERDICT_EARLY;
      out_word.tokens_left = bucket_ff;
      case (state_ff)
         BACK_IDLE: begin
            cls_pop = ~cls_empty;
            item_in = cls_word;
         end
         BACK_REFILL: begin
            if (!item_ff.early && (item_ff.now_ms > due_ms)) begin
               if (item_ff.now_ms > gap_ms) begin
                  bucket_in = {16'b0, cfg.initial_tokens};
                  last_in   = item_ff.now_ms;
               end else begin
                  bucket_in = topped[32] ? 32'hFFFF_FFFF : topped[31:0];
                  last_in   = due_ms;
               end
            end
         end
         BACK_SPEND: begin
            out_push = ~out_full;
            if (item_ff.early) begin
               out_word.verdict = VERDICT_EARLY;
            end else if (bucket_ff < cost) begin
               out_word.verdict = VERDICT_NO_TOKENS;
            end else begin
               out_word.verdict     = VERDICT_SEND;
               out_word.tokens_left = bucket_ff - cost;
            end
            if (!out_full) begin
               bucket_in = out_word.tokens_left;
            end
         end
         default: begin
            cls_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BACK_IDLE;
         bucket_ff <= {16'b0, INITIAL_TOKENS_RST};
         last_ff   <= 32'd0;
      end else begin
         state_ff  <= state_in;
         bucket_ff <= bucket_in;
         last_ff   <= last_in;
      end
   end

endmodule

// File: rtl/audio_packet_token_bucket_top.sv
// A word accepted by the front passes its stages, the class queue and the bucket
// sequencer (pop, refill, spend, one word at a time; spend waits while the response
// queue is full); the front takes no new word while its first stage still holds one.
// Reset (synchronous, active high): registers to defaults, bucket to 6600,
// last refill time to 0, all queues empty.
module audio_packet_token_bucket_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  aptb_pkg::req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output aptb_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import aptb_pkg::*;

   cfg_type cfg;
   cls_type cls_in_word, cls_out_word;
   rsp_type out_word;
   logic    cls_push, cls_full, cls_pop, cls_empty;
   logic    out_push, out_full;

   aptb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   aptb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cls_push (cls_push),
      .cls_word (cls_in_word),
      .cls_full (cls_full)
   );

   aptb_fifo #(.word_type(cls_type)) u_cls_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cls_push),
      .push_word (cls_in_word),
      .full      (cls_full),
      .pop       (cls_pop),
      .pop_word  (cls_out_word),
      .empty     (cls_empty)
   );

   aptb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cls_empty (cls_empty),
      .cls_word  (cls_out_word),
      .cls_pop   (cls_pop),
      .out_push  (out_push),
      .out_word  (out_word),
      .out_full  (out_full)
   );

   aptb_fifo #(.word_type(rsp_type)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_word (out_word),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_word  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

// File: verif/tb_audio_packet_token_bucket_top.sv
module tb_audio_packet_token_bucket_top;
   import aptb_pkg::*;

   localparam int unsigned PHASE_WORDS   = 140;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PRINT_CAP     = 40;
   localparam int unsigned REFILL_WORDS  = 16;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type want;
   } probe_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_push    = 1'b0;
   req_type     req_data    = '0;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop     = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   cfg_type     pred_cfg = {INITIAL_TOKENS_RST, REFILL_TOKENS_RST,
                            REFILL_INTERVAL_MS_RST, RESET_GAP_MS_RST};
   logic [31:0] pred_level   = {16'd0, INITIAL_TOKENS_RST};
   logic [31:0] pred_last_ms = '0;

   rsp_type     verdict_q[$];
   probe_type   probes[$];
   int unsigned fault_count = 0;
   bit          fast_mode   = 1'b0;
   bit          hold_req    = 1'b0;
   int unsigned hold_left   = 0;
   logic [31:0] stim_ms     = '0;

   audio_packet_token_bucket_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #32_000_000;
      $display("tb_audio_packet_token_bucket_top: errors");
      $finish;
   end

   task automatic report_fault(input string what);
      fault_count++;
      // keep the log short if everything goes wrong at once
      if (fault_count <= PRINT_CAP)
         $display("%0t mismatch: %s", $time, what);
   endtask

   function automatic logic [31:0] early_window(input logic [15:0] init,
                                                input logic [17:0] rate);
      logic [31:0] num;
      num = 32'(init) * 32'd1000;
      if (rate == '0)
         return '1;
      return num / 32'(rate);
   endfunction

   function automatic rsp_type predict_verdict(input req_type w);
      rsp_type     r;
      logic [31:0] due_ms;
      logic [31:0] stale_ms;
      logic [32:0] sum;
      due_ms   = pred_last_ms + 32'(pred_cfg.refill_interval_ms);
      stale_ms = pred_last_ms + pred_cfg.reset_gap_ms;
      if (w.play_time_ms != '0 && w.play_time_ms > w.now_ms &&
          (w.play_time_ms - w.now_ms) > early_window(pred_cfg.initial_tokens,
                                                     w.sample_rate)) begin
         r.verdict = VERDICT_EARLY;
      end else begin
         if (w.now_ms > due_ms) begin
            if (w.now_ms > stale_ms) begin
               pred_level   = 32'(pred_cfg.initial_tokens);
               pred_last_ms = w.now_ms;
            end else begin
               sum          = {1'b0, pred_level} + 33'(pred_cfg.refill_tokens);
               pred_level   = sum[32] ? '1 : sum[31:0];
               pred_last_ms = due_ms;
            end
         end
         if (pred_level < 32'(w.packet_samples)) begin
            r.verdict = VERDICT_NO_TOKENS;
         end else begin
            pred_level = pred_level - 32'(w.packet_samples);
            r.verdict  = VERDICT_SEND;
         end
      end
      r.tokens_left = pred_level;
      return r;
   endfunction

   function automatic req_type random_word();
      req_type     w;
      logic [31:0] window;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 4)
         stim_ms = $urandom;
      else if (pick < 12)
         stim_ms = stim_ms + pred_cfg.reset_gap_ms + $urandom_range(1, 40);
      else
         stim_ms = stim_ms + $urandom_range(0, 2 * pred_cfg.refill_interval_ms + 2);
      w.now_ms = stim_ms;

      pick = $urandom_range(99);
      if (pick < 70)
         w.packet_samples = 16'($urandom_range(0, 2 * pred_cfg.refill_tokens + 64));
      else if (pick < 85)
         w.packet_samples = 16'($urandom);
      else if (pick < 93)
         w.packet_samples = '0;
      else
         w.packet_samples = '1;

      pick = $urandom_range(99);
      if (pick < 55) begin
         case ($urandom_range(5))
            0: w.sample_rate = 18'd8000;
            1: w.sample_rate = 18'd22050;
            2: w.sample_rate = 18'd44100;
            3: w.sample_rate = 18'd48000;
            4: w.sample_rate = 18'd96000;
            default: w.sample_rate = 18'd192000;
         endcase
      end else if (pick < 90) begin
         w.sample_rate = 18'($urandom_range(1, 192000));
      end else if (pick < 97) begin
         w.sample_rate = 18'($urandom);
      end else begin
         w.sample_rate = '0;
      end

      // aim play times around the early window edge
      window = early_window(pred_cfg.initial_tokens, w.sample_rate);
      pick = $urandom_range(99);
      if (pick < 30)
         w.play_time_ms = '0;
      else if (pick < 75)
         w.play_time_ms = w.now_ms + ((window > 32'd100000) ? $urandom
                                      : $urandom_range(0, 2 * window + 2));
      else if (pick < 88)
         w.play_time_ms = $urandom;
      else
         w.play_time_ms = w.now_ms - $urandom_range(0, 50);
      return w;
   endfunction

   // entered and left at a falling edge
   task automatic push_word(input req_type w, input bit typed, input rsp_type want);
      int unsigned gap;
      rsp_type     prediction;
      gap = 0;
      if (!fast_mode)
         while ($urandom_range(99) < 36) gap++;
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_full);
      prediction = predict_verdict(w);
      verdict_q.push_back(typed ? want : prediction);
      @(negedge clock);
   endtask

   task automatic drain(input int unsigned tail);
      req_push <= 1'b0;
      while (verdict_q.size() != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] stored;
      case (idx)
         CSR_INITIAL_TOKENS: begin
            stored = {16'd0, value[15:0]};
            pred_cfg.initial_tokens = value[15:0];
         end
         CSR_REFILL_TOKENS: begin
            stored = {16'd0, value[15:0]};
            pred_cfg.refill_tokens = value[15:0];
         end
         CSR_REFILL_INTERVAL_MS: begin
            stored = {16'd0, value[15:0]};
            pred_cfg.refill_interval_ms = value[15:0];
         end
         default: begin
            stored = value;
            pred_cfg.reset_gap_ms = value;
         end
      endcase
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== stored)
         report_fault($sformatf("csr %s read %h, wrote %h", idx.name(), csr_prdata,
                                stored));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // upper bits of the 16-bit registers get junk, which must be dropped
   task automatic apply_cfg(input cfg_type c);
      csr_write(CSR_INITIAL_TOKENS, {16'($urandom), c.initial_tokens});
      csr_write(CSR_REFILL_TOKENS, {16'($urandom), c.refill_tokens});
      csr_write(CSR_REFILL_INTERVAL_MS, {16'($urandom), c.refill_interval_ms});
      csr_write(CSR_RESET_GAP_MS, c.reset_gap_ms);
   endtask

   task automatic add_probe(input logic [31:0] now, input logic [15:0] samples,
                            input logic [31:0] play, input logic [17:0] rate,
                            input bit typed = 1'b0,
                            input verdict_type v = VERDICT_SEND,
                            input logic [31:0] tokens = '0);
      probe_type p;
      p.word  = {now, samples, play, rate};
      p.typed = typed;
      p.want  = {v, tokens};
      probes.push_back(p);
   endtask

   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (reset || hold_left != 0) begin
         rsp_pop <= 1'b0;
         if (hold_left != 0)
            hold_left--;
      end else begin
         rsp_pop <= fast_mode || ($urandom_range(99) >= 36);
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (verdict_q.size() == 0) begin
            report_fault($sformatf("word with nothing outstanding: %0d %h",
                                   rsp_data.verdict, rsp_data.tokens_left));
         end else begin
            want = verdict_q.pop_front();
            if (rsp_data.verdict !== want.verdict)
               report_fault($sformatf("verdict %0d, want %0d", rsp_data.verdict,
                                      want.verdict));
            if (rsp_data.tokens_left !== want.tokens_left)
               report_fault($sformatf("tokens_left %h, want %h",
                                      rsp_data.tokens_left, want.tokens_left));
         end
      end
   end

   initial begin : stimulus
      cfg_type     plan [5];
      rsp_type     none;
      int unsigned n;

      none    = '0;
      plan[0] = {INITIAL_TOKENS_RST, REFILL_TOKENS_RST, REFILL_INTERVAL_MS_RST,
                 RESET_GAP_MS_RST};
      plan[1] = '0;
      plan[2] = '1;
      plan[3] = {16'($urandom), 16'($urandom_range(0, 2000)),
                 16'($urandom_range(1, 40)), 32'($urandom_range(40, 3000))};
      plan[4] = {16'($urandom), 16'($urandom), 16'($urandom), 32'($urandom)};

      // defaults: bucket 6600, last refill 0
      add_probe(32'd0, 16'd0, 32'd0, 18'd48000, 1, VERDICT_SEND, 32'd6600);
      add_probe(32'd5, 16'hFFFF, 32'd0, 18'd44100, 1, VERDICT_NO_TOKENS, 32'd6600);
      // window at 192 kHz is 34 ms
      add_probe(32'd5, 16'd100, 32'd40, 18'd192000, 1, VERDICT_EARLY, 32'd6600);
      add_probe(32'd5, 16'd600, 32'd39, 18'd192000, 1, VERDICT_SEND, 32'd6000);
      // zero rate: never early
      add_probe(32'd5, 16'd0, 32'hFFFF_FFFF, 18'd0, 1, VERDICT_SEND, 32'd6000);
      add_probe(32'd5, 16'd1, 32'd31, 18'h3FFFF, 1, VERDICT_EARLY, 32'd6000);
      add_probe(32'd5, 16'd1, 32'd30, 18'h3FFFF);
      add_probe(32'd3, 16'd5, 32'd2, 18'd48000);
      add_probe(32'd11, 16'd0, 32'd0, 18'd44100);
      add_probe(32'd20, 16'd0, 32'd0, 18'd44100);
      add_probe(32'd21, 16'd6435, 32'd0, 18'd44100);
      add_probe(32'd500, 16'd0, 32'd0, 18'd22050);
      add_probe(32'd1000, 16'hFFFF, 32'h8000_0000, 18'h2AAAA);
      add_probe(32'hFFFF_FFFF, 16'hFFFF, 32'd0, 18'd1);
      // refill deadline wraps past zero
      add_probe(32'd20, 16'd100, 32'd0, 18'd48000);
      add_probe(32'h5555_5555, 16'hAAAA, 32'h5555_5555, 18'h2AAAA);
      add_probe(32'hAAAA_AAAA, 16'h5555, 32'hAAAA_AAAB, 18'h15555);
      add_probe(32'hAAAA_AAB0, 16'd0, 32'd0, 18'd8000);

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (probes[i])
         push_word(probes[i].word, probes[i].typed, probes[i].want);
      drain(SETTLE_CYCLES);

      // full-size refill on every word, gap chosen so it never resets
      fast_mode = 1'b1;
      apply_cfg({pred_cfg.initial_tokens, 16'hFFFF, 16'd0, ~pred_last_ms});
      n = 0;
      while (n < REFILL_WORDS) begin
         push_word({pred_last_ms + 32'd1, 16'd0, 32'd0, 18'd48000}, 1'b0, none);
         n++;
      end
      push_word({pred_last_ms + 32'd1, 16'hFFFF, 32'd0, 18'd48000}, 1'b0, none);
      drain(SETTLE_CYCLES);

      foreach (plan[p]) begin
         apply_cfg(plan[p]);
         stim_ms   = pred_last_ms;
         fast_mode = (p == 2);
         if (p == 1)
            hold_req = 1'b1;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (i == PHASE_WORDS / 2)
               drain(0);
            push_word(random_word(), 1'b0, none);
         end
         drain(SETTLE_CYCLES);
      end

      if (fault_count == 0)
         $display("tb_audio_packet_token_bucket_top: clean");
      else
         $display("tb_audio_packet_token_bucket_top: errors");
      $finish;
   end

endmodule

// File: sim.f
rtl/aptb_pkg.sv
rtl/aptb_csr.sv
rtl/aptb_fifo.sv
rtl/aptb_front.sv
rtl/aptb_back.sv
rtl/audio_packet_token_bucket_top.sv
verif/tb_audio_packet_token_bucket_top.sv
